// ===== rtl/core/kwsc_pkg.sv =====
// ----------------------------------------------------------------------------
// kwsc_pkg : shared types and constants for the keyword substitution cipher
// Table geometry, letter range, action codes and sequencer/RAM interfaces.
// ----------------------------------------------------------------------------
package kwsc_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int ADDR_W        = $clog2(ALPHABET_SIZE);
    localparam int FILL_W        = $clog2(ALPHABET_SIZE + 1);

    localparam logic [7:0] LETTER_FIRST = 8'h41;
    localparam logic [7:0] LETTER_LAST  = 8'h5A;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_KEYWORD = 2'd1,
        ACT_FINISH  = 2'd2,
        ACT_ENCRYPT = 2'd3
    } act_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_CMP  = 4'b0100,
        S_LOAD = 4'b1000
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic       load;
        logic [7:0] cipher;
        logic       last;
    } result_t;

endpackage

// ===== rtl/core/kwsc_key_ram.sv =====
// ----------------------------------------------------------------------------
// kwsc_key_ram : key table storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kwsc_key_ram
    import kwsc_pkg::*;
(
    input  logic       clk,
    input  ram_req_t   req,
    output logic [7:0] rdata
);

    logic [7:0] key_mem_reg [ALPHABET_SIZE];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            key_mem_reg[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= key_mem_reg[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/kwsc_seq.sv =====
// ----------------------------------------------------------------------------
// kwsc_seq : table builder and lookup sequencer
// Walks the held entries through one byte comparator, appends new bytes,
// steps through A..Z on finish and fetches the substitute on encrypt.
// ----------------------------------------------------------------------------
module kwsc_seq
    import kwsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic [7:0] rdata,
    input  logic       res_free,
    output ram_req_t   ram_req,
    output result_t    res
);

    seq_state_t        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [7:0]        cand_reg, cand_next;
    logic              finish_reg, finish_next;
    logic              pass_reg, pass_next;
    logic              last_reg, last_next;

    logic [7:0]        idx_in;
    logic              is_letter;
    logic              full;
    logic              cand_is_z;
    logic              hit;
    logic              scan_end;
    logic [FILL_W-1:0] fill_inc;

    always_comb
    begin
        idx_in    = data_byte - LETTER_FIRST;
        is_letter = (data_byte >= LETTER_FIRST) && (data_byte <= LETTER_LAST);
        full      = (fill_reg == FILL_W'(ALPHABET_SIZE));
        cand_is_z = (cand_reg == LETTER_LAST);
        hit       = (rdata == cand_reg);
        fill_inc  = fill_reg + FILL_W'(1);
        scan_end  = ({{(FILL_W-ADDR_W){1'b0}}, k_reg} == fill_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        k_next      = k_reg;
        cand_next   = cand_reg;
        finish_next = finish_reg;
        pass_next   = pass_reg;
        last_next   = last_reg;

        ram_req       = '0;
        ram_req.waddr = fill_reg[ADDR_W-1:0];
        ram_req.wdata = cand_reg;
        ram_req.raddr = k_reg;

        res        = '0;
        res.last   = last_reg;
        res.cipher = cand_reg;

        in_ready = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                ram_req.raddr = idx_in[ADDR_W-1:0];
                if (in_valid)
                begin
                    case (act_t'(action))
                        ACT_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        ACT_KEYWORD:
                        begin
                            if ((data_byte != 8'h00) && !full)
                            begin
                                cand_next   = data_byte;
                                k_next      = '0;
                                finish_next = 1'b0;
                                state_next  = S_SCAN;
                            end
                        end
                        ACT_FINISH:
                        begin
                            if (!full)
                            begin
                                cand_next   = LETTER_FIRST;
                                k_next      = '0;
                                finish_next = 1'b1;
                                state_next  = S_SCAN;
                            end
                        end
                        ACT_ENCRYPT:
                        begin
                            cand_next  = is_letter ? idx_in : data_byte;
                            pass_next  = !is_letter;
                            last_next  = last_byte;
                            state_next = S_LOAD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    // not held: append at the fill point
                    ram_req.we = 1'b1;
                    fill_next  = fill_inc;
                    if (finish_reg && !cand_is_z && (fill_inc != FILL_W'(ALPHABET_SIZE)))
                    begin
                        cand_next = cand_reg + 8'd1;
                        k_next    = '0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (hit)
                begin
                    if (finish_reg && !cand_is_z)
                    begin
                        cand_next  = cand_reg + 8'd1;
                        k_next     = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    k_next     = k_reg + ADDR_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_LOAD:
            begin
                ram_req.raddr = cand_reg[ADDR_W-1:0];
                if (pass_reg)
                begin
                    res.cipher = cand_reg;
                end
                else if ({{(FILL_W-ADDR_W){1'b0}}, cand_reg[ADDR_W-1:0]} < fill_reg)
                begin
                    res.cipher = rdata;
                end
                else
                begin
                    res.cipher = 8'h00;
                end
                res.load = res_free;
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            finish_reg <= 1'b0;
            pass_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            finish_reg <= finish_next;
            pass_reg   <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        cand_reg <= cand_next;
        last_reg <= last_next;
    end

endmodule

// ===== rtl/core/keyword_substitution_cipher.sv =====
// ----------------------------------------------------------------------------
// keyword_substitution_cipher : keyword-mixed substitution alphabet encryptor
// Input beats carry action, data_byte and last_byte on a valid/ready channel.
// Clear empties the 26-entry key table. A keyword beat is checked against the
// held entries one at a time, each in a scan and a compare state, through a
// single comparator and appended if new. Finish walks A..Z through the same
// loop. Encrypt reads the table once: the beat is taken into a load state, and
// the result enters the output register as in_ready goes back high, so no new
// beat is taken before the last result is in the output register.
// Only encrypt beats give an output beat (cipher_byte, last_out). The
// output register lets one result wait while the next input beat is taken; a
// further encrypt waits in the sequencer until out_ready frees the register.
// in_ready is low while a beat is being worked.
// Reset empties the table (fill count zero); entries beyond the fill count
// read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher
    import kwsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] cipher_byte,
    output logic       last_out
);

    ram_req_t   ram_req;
    result_t    res;
    logic [7:0] rdata;
    logic       res_free;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] cipher_reg;
    logic       last_out_reg;

    kwsc_key_ram u_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    kwsc_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .rdata     (rdata),
        .res_free  (res_free),
        .ram_req   (ram_req),
        .res       (res)
    );

    always_comb
    begin
        res_free       = !out_valid_reg || out_ready;
        out_valid_next = res.load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            cipher_reg   <= res.cipher;
            last_out_reg <= res.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cipher_byte = cipher_reg;
    assign last_out    = last_out_reg;

endmodule

// ===== sim/tb_keyword_substitution_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyword_substitution_cipher : self-checking bench for the cipher block
// Walks a directed table of beats, then random clear/keyword/finish/encrypt
// sequences with noise. A local model of the key table predicts each cipher
// beat without a typed expectation. Both channels idle at random, and the sink
// sometimes holds off long enough for the block to back up.
// ----------------------------------------------------------------------------
module tb_keyword_substitution_cipher;
    import kwsc_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int BEAT_TARGET = 1100;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_SPACING = 580;
    localparam int IDLE_LIMIT  = 20000;
    localparam int TAIL_CYCLES = 50;
    localparam int N_DIRECTED  = 26;

    typedef struct packed {
        logic [7:0] cipher;
        logic       last;
    } cipher_beat_t;

    typedef struct {
        act_t       act;
        logic [7:0] data;
        logic       last;
        bit         fixed;
        logic [7:0] want;
    } stim_row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [1:0] action    = ACT_CLEAR;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] cipher_byte;
    logic       last_out;

    logic [7:0]   mix_table [ALPHABET_SIZE];
    int           mix_fill;
    cipher_beat_t cipher_fifo [$];

    int errors       = 0;
    int beats_done   = 0;
    int results_seen = 0;
    int stall_cycles = 0;
    int tx_calm      = 0;
    int rx_calm      = 0;
    int rx_wait      = 0;
    int next_hold    = 120;

    // typed expectations: reset/clear reads zero, non-letters pass, plain alphabet
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ACT_ENCRYPT, 8'h41, 1'b0, 1'b1, 8'h00},
        '{ACT_ENCRYPT, 8'h5A, 1'b1, 1'b1, 8'h00},
        '{ACT_ENCRYPT, 8'h00, 1'b0, 1'b1, 8'h00},
        '{ACT_ENCRYPT, 8'hFF, 1'b1, 1'b1, 8'hFF},
        '{ACT_ENCRYPT, 8'h40, 1'b0, 1'b1, 8'h40},
        '{ACT_ENCRYPT, 8'h5B, 1'b0, 1'b1, 8'h5B},
        '{ACT_ENCRYPT, 8'h61, 1'b1, 1'b1, 8'h61},
        '{ACT_FINISH,  8'hA5, 1'b1, 1'b0, 8'h00},
        '{ACT_ENCRYPT, 8'h41, 1'b0, 1'b1, 8'h41},
        '{ACT_ENCRYPT, 8'h5A, 1'b1, 1'b1, 8'h5A},
        '{ACT_FINISH,  8'h00, 1'b0, 1'b0, 8'h00},
        '{ACT_KEYWORD, 8'h51, 1'b0, 1'b0, 8'h00},
        '{ACT_ENCRYPT, 8'h51, 1'b0, 1'b1, 8'h51},
        '{ACT_CLEAR,   8'hFF, 1'b1, 1'b0, 8'h00},
        '{ACT_ENCRYPT, 8'h4D, 1'b1, 1'b1, 8'h00},
        '{ACT_KEYWORD, 8'h4B, 1'b0, 1'b0, 8'h00},
        '{ACT_KEYWORD, 8'h45, 1'b0, 1'b0, 8'h00},
        '{ACT_KEYWORD, 8'h59, 1'b1, 1'b0, 8'h00},
        '{ACT_KEYWORD, 8'h45, 1'b0, 1'b0, 8'h00},
        '{ACT_KEYWORD, 8'h00, 1'b0, 1'b0, 8'h00},
        '{ACT_KEYWORD, 8'hFF, 1'b0, 1'b0, 8'h00},
        '{ACT_FINISH,  8'h00, 1'b0, 1'b0, 8'h00},
        '{ACT_ENCRYPT, 8'h41, 1'b0, 1'b0, 8'h00},
        '{ACT_ENCRYPT, 8'h42, 1'b0, 1'b0, 8'h00},
        '{ACT_ENCRYPT, 8'h44, 1'b0, 1'b0, 8'h00},
        '{ACT_ENCRYPT, 8'h5A, 1'b1, 1'b0, 8'h00}
    };

    keyword_substitution_cipher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cipher_byte (cipher_byte),
        .last_out    (last_out)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic bit mix_holds(logic [7:0] b);
        for (int k = 0; k < mix_fill; k++)
            if (mix_table[k] == b)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit mix_append(logic [7:0] b);
        if (mix_fill >= ALPHABET_SIZE || mix_holds(b))
            return 1'b0;
        mix_table[mix_fill] = b;
        mix_fill++;
        return 1'b1;
    endfunction

    // returns whether the beat changed anything or gave a result
    function automatic bit mix_step(act_t a, logic [7:0] d, logic l,
                                    output bit produced, output cipher_beat_t res);
        bit changed;
        changed  = 1'b0;
        produced = 1'b0;
        res      = '0;
        case (a)
            ACT_CLEAR:
            begin
                foreach (mix_table[k])
                    mix_table[k] = 8'h00;
                mix_fill = 0;
                changed  = 1'b1;
            end
            ACT_KEYWORD:
            begin
                if (d != 8'h00)
                    changed = mix_append(d);
            end
            ACT_FINISH:
            begin
                for (int c = int'(LETTER_FIRST); c <= int'(LETTER_LAST); c++)
                    if (mix_append(8'(c)))
                        changed = 1'b1;
            end
            default:
            begin
                produced = 1'b1;
                changed  = 1'b1;
                res.last = l;
                if (d >= LETTER_FIRST && d <= LETTER_LAST)
                    res.cipher = mix_table[d - LETTER_FIRST];
                else
                    res.cipher = d;
            end
        endcase
        return changed;
    endfunction

    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte(int letter_pct);
        if ($urandom_range(0, 99) < letter_pct)
            return 8'(int'(LETTER_FIRST) + $urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    // entered and left at a falling edge
    task automatic send_beat(act_t a, logic [7:0] d, logic l, bit fixed, logic [7:0] want);
        int           gap;
        bit           produced;
        cipher_beat_t res;
        gap = idle_len(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        action    <= a;
        data_byte <= d;
        last_byte <= l;
        do
            @(posedge clk);
        while (!in_ready);
        if (mix_step(a, d, l, produced, res))
            beats_done++;
        if (produced)
        begin
            if (fixed)
                res.cipher = want;
            cipher_fifo.push_back(res);
        end
        @(negedge clk);
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++)
            send_beat(ACT_ENCRYPT, pick_byte(75), 1'(i == len - 1), 1'b0, 8'h00);
    endtask

    task automatic random_traffic();
        int r;
        int klen;
        int kpct;
        while (beats_done < BEAT_TARGET)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
            begin
                send_beat(ACT_CLEAR, 8'($urandom), 1'($urandom), 1'b0, 8'h00);
                klen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 12);
                kpct = ($urandom_range(0, 3) == 0) ? 30 : 90;
                repeat (klen)
                    send_beat(ACT_KEYWORD, pick_byte(kpct), 1'($urandom), 1'b0, 8'h00);
                if ($urandom_range(0, 9) != 0)
                    send_beat(ACT_FINISH, 8'($urandom), 1'($urandom), 1'b0, 8'h00);
                send_message($urandom_range(1, 40));
            end
            else if (r < 8)
                send_message($urandom_range(1, 40));
            else
            begin
                repeat ($urandom_range(1, 8))
                    send_beat(act_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                              1'b0, 8'h00);
            end
        end
    endtask

    // sink side: random stalls, plus the occasional long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (rx_wait > 0)
            begin
                out_ready <= 1'b0;
                rx_wait--;
            end
            else if (results_seen >= next_hold)
            begin
                out_ready <= 1'b0;
                rx_wait   = HOLD_CYCLES - 1;
                next_hold += HOLD_SPACING;
            end
            else
            begin
                out_ready <= 1'b1;
                rx_wait   = idle_len(rx_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        cipher_beat_t want;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (cipher_fifo.size() == 0)
                    report_mismatch("beat with none pending, cipher_byte", cipher_byte, 0);
                else
                begin
                    want = cipher_fifo.pop_front();
                    if (cipher_byte !== want.cipher)
                        report_mismatch("cipher_byte", cipher_byte, want.cipher);
                    if (last_out !== want.last)
                        report_mismatch("last_out", last_out, want.last);
                end
            end
            if (stall_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        foreach (mix_table[k])
            mix_table[k] = 8'h00;
        mix_fill = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed_rows[i])
            send_beat(directed_rows[i].act, directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].fixed, directed_rows[i].want);
        random_traffic();
        in_valid <= 1'b0;
        while (cipher_fifo.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
